// File: src/fpas_pkg.sv
// Package for the binary32 add/subtract block: payload types and constants.
// No dependencies.
package fpas_pkg;

   localparam logic [7:0]  EXP_MAX     = 8'd255;
   localparam logic [22:0] QUIET_BIT   = 23'h400000;
   localparam logic [31:0] DEFAULT_NAN = 32'h7fc00000;
   localparam logic        CMD_ADD     = 1'b0;
   localparam logic        CMD_SUB     = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        invalid;
      logic        overflow;
   } rsp_type;

endpackage

// File: src/fpas_req_if.sv
// Valid/ready channel carrying one add/subtract request item.
// Depends on fpas_pkg.
interface fpas_req_if;
   import fpas_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/fpas_rsp_if.sv
// Valid/ready channel carrying one add/subtract result item.
// Depends on fpas_pkg.
interface fpas_rsp_if;
   import fpas_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/fpas_core.sv
// Combinational binary32 add/subtract datapath: align, add, normalize, round.
// Depends on fpas_pkg.
module fpas_core (
   input  fpas_pkg::req_type req,
   output fpas_pkg::rsp_type rsp
);
   import fpas_pkg::*;

   logic [31:0] b_eff;
   logic        sa, sb, big_s;
   logic [7:0]  ea, eb, xa, xb, big_x, d;
   logic [22:0] fa, fb;
   logic [26:0] ma, mb, big_m, small_m, aligned;
   logic [27:0] sum;
   logic [26:0] m1;
   logic [8:0]  e1;
   logic [4:0]  lz;
   logic [4:0]  sh;
   logic [26:0] mn;
   logic [8:0]  en;
   logic [24:0] sig;
   logic        rnd_up;
   logic [8:0]  ef;
   logic [23:0] sig_f;
   logic [53:0] wide;
   logic        a_nan, b_nan;

   always_comb begin
      b_eff = req.operand_b ^ {(req.cmd == CMD_SUB), 31'd0};
      sa = req.operand_a[31];
      sb = b_eff[31];
      ea = req.operand_a[30:23];
      eb = req.operand_b[30:23];
      fa = req.operand_a[22:0];
      fb = req.operand_b[22:0];
      a_nan = (ea == EXP_MAX) && (fa != '0);
      b_nan = (eb == EXP_MAX) && (fb != '0);

      ma = {(ea != 8'd0), fa, 3'b000};
      mb = {(eb != 8'd0), fb, 3'b000};
      xa = (ea != 8'd0) ? ea : 8'd1;
      xb = (eb != 8'd0) ? eb : 8'd1;
      if (xa > xb || (xa == xb && ma >= mb)) begin
         big_s = sa; big_x = xa; big_m = ma; small_m = mb; d = xa - xb;
      end else begin
         big_s = sb; big_x = xb; big_m = mb; small_m = ma; d = xb - xa;
      end

      // sticky right shift: every bit pushed out lands in bit 0
      wide = {small_m, 27'd0} >> ((d > 8'd31) ? 6'd31 : d[5:0]);
      if (d == 8'd0) aligned = small_m;
      else if (d >= 8'd31) aligned = {26'd0, (small_m != '0)};
      else aligned = wide[53:27] | {26'd0, (wide[26:0] != '0)};

      sum = (sa == sb) ? {1'b0, big_m} + {1'b0, aligned}
                       : {1'b0, big_m} - {1'b0, aligned};

      if (sum[27]) begin
         m1 = sum[27:1] | {26'd0, sum[0]};
         e1 = {1'b0, big_x} + 9'd1;
      end else begin
         m1 = sum[26:0];
         e1 = {1'b0, big_x};
      end

      // leading zeros, shift limited so exponent stops at 1
      lz = 5'd27;
      for (int i = 0; i < 27; i++)
         if (m1[i]) lz = 5'(26 - i);
      sh = ({4'd0, lz} < (e1 - 9'd1)) ? lz : 5'((e1 - 9'd1));
      mn = m1 << sh;
      en = e1 - {4'd0, sh};
      if (!mn[26]) en = 9'd0;

      rnd_up = mn[2] && (mn[1:0] != 2'd0 || mn[3]);
      sig = {1'b0, mn[26:3]} + {24'd0, rnd_up};
      ef = en;
      sig_f = sig[23:0];
      if (sig[24]) begin
         sig_f = sig[24:1];
         ef = en + 9'd1;
      end else if (en == 9'd0 && sig[23]) begin
         ef = 9'd1;
      end

      rsp.invalid  = 1'b0;
      rsp.overflow = 1'b0;
      if (a_nan) begin
         rsp.result  = req.operand_a | {9'd0, QUIET_BIT};
         rsp.invalid = 1'b1;
      end else if (b_nan) begin
         rsp.result  = req.operand_b | {9'd0, QUIET_BIT};
         rsp.invalid = 1'b1;
      end else if (ea == EXP_MAX && eb == EXP_MAX && sa != sb) begin
         rsp.result  = DEFAULT_NAN;
         rsp.invalid = 1'b1;
      end else if (ea == EXP_MAX) begin
         rsp.result = {sa, EXP_MAX, 23'd0};
      end else if (eb == EXP_MAX) begin
         rsp.result = {sb, EXP_MAX, 23'd0};
      end else if (sum == '0) begin
         rsp.result = {sa & sb, 31'd0};
      end else if (ef >= {1'b0, EXP_MAX}) begin
         rsp.result   = {big_s, EXP_MAX, 23'd0};
         rsp.overflow = 1'b1;
      end else begin
         rsp.result = {big_s, ef[7:0], sig_f[22:0]};
      end
   end
endmodule

// File: src/fp32_add_subtract.sv
// Top level of the binary32 adder/subtractor: input register, datapath, output register.
// Depends on fpas_pkg, fpas_req_if, fpas_rsp_if and fpas_core.
//
// IEEE 754 single-precision add/subtract, round to nearest even. An item is
// accepted every cycle while req_ready is high, and its result is loaded into
// the result register at the next advance: the align/add/normalize/round path
// sits between the input register and the result register, so the item waits
// in the input register while that path settles. The two stages advance
// together when the result register is empty or being taken, so req_ready
// drops only while a result waits downstream with the pipeline full. NaN
// inputs return the first NaN quieted with invalid set; inf - inf returns the
// default NaN; overflow gives a signed infinity with overflow set.
module fp32_add_subtract (
   input logic clock,
   input logic reset,
   fpas_req_if.sink   req_ch,
   fpas_rsp_if.source rsp_ch
);
   import fpas_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff, core_rsp;
   logic    adv;

   // pipeline moves when the result slot is free or draining
   assign adv = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv || !in_vld_ff;
   assign in_vld_in  = req_ch.valid ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign out_vld_in = adv ? in_vld_ff : out_vld_ff;

   fpas_core u_core (.req(in_data_ff), .rsp(core_rsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_ch.ready) in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_ch.valid && req_ch.ready) in_data_ff <= req_ch.payload;
      if (adv) out_data_ff <= core_rsp;
   end

   assign rsp_ch.valid   = out_vld_ff;
   assign rsp_ch.payload = out_data_ff;

   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.payload))
      else $error("result changed while stalled");
   // a waiting input item is never dropped
   a_keep: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !adv |=> in_vld_ff)
      else $error("input item lost");
   // an accepted item reaches the result register on advance
   a_move: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && adv |=> out_vld_ff)
      else $error("result missing");
endmodule
